>>> sv/udp_ipv4_header_builder_top_macros.svh
// assertion helpers for the header builder back end
`ifndef UDP_IPV4_HEADER_BUILDER_TOP_MACROS_SVH
`define UDP_IPV4_HEADER_BUILDER_TOP_MACROS_SVH

// same-cycle implication on the local clock, off during reset
`define UDPHB_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication on the local clock, off during reset
`define UDPHB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/udphb_pkg.sv
`default_nettype none

package udphb_pkg;

   // payload limits
   localparam logic [16:0] MAX_PAYLOAD = 17'd65507;
   localparam logic [16:0] COUNT_CAP   = 17'd65508;

   // fixed header fields
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [15:0] IP_VER_IHL     = 16'h4500;
   localparam logic [15:0] IP_IDENT       = 16'h0000;
   localparam logic [15:0] IP_FLAGS_DF    = 16'h4000;
   localparam logic [7:0]  IP_TTL         = 8'd64;
   localparam logic [7:0]  IP_PROTO_UDP   = 8'h11;
   localparam logic [15:0] IP_TTL_PROTO   = {IP_TTL, IP_PROTO_UDP};
   localparam logic [15:0] UDP_HDR_LEN    = 16'd8;
   localparam logic [15:0] IP_HDR_LEN     = 16'd20;
   localparam logic [15:0] UDP_CK_ZERO    = 16'hffff;
   localparam logic [15:0] UDP_LEN_SAT    = 16'(MAX_PAYLOAD) + UDP_HDR_LEN;

   // header shape
   localparam int          HDR_WORDS     = 21;
   localparam int          IDX_W         = $clog2(HDR_WORDS);
   localparam logic [IDX_W-1:0] LAST_WORD_IDX = IDX_W'(HDR_WORDS - 1);

   // checksum accumulator, room for sixteen 16-bit terms
   localparam int SUM_W = 20;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register port
   localparam int REG_COUNT  = 6;
   localparam int CSR_ADDR_W = $clog2(REG_COUNT * 8);
   localparam int CSR_DATA_W = 64;
   localparam int REG_IDX_W  = CSR_ADDR_W - 3;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_DST_MAC  = 0,
      REG_SRC_MAC  = 1,
      REG_SRC_IP   = 2,
      REG_DST_IP   = 3,
      REG_SRC_PORT = 4,
      REG_DST_PORT = 5
   } reg_idx_type;

   // header word positions
   typedef enum logic [IDX_W-1:0] {
      W_DST_MAC_HI  = 0,
      W_DST_MAC_MID = 1,
      W_DST_MAC_LO  = 2,
      W_SRC_MAC_HI  = 3,
      W_SRC_MAC_MID = 4,
      W_SRC_MAC_LO  = 5,
      W_ETHERTYPE   = 6,
      W_VER_IHL     = 7,
      W_TOT_LEN     = 8,
      W_IDENT       = 9,
      W_FLAGS       = 10,
      W_TTL_PROTO   = 11,
      W_IP_CK       = 12,
      W_SRC_IP_HI   = 13,
      W_SRC_IP_LO   = 14,
      W_DST_IP_HI   = 15,
      W_DST_IP_LO   = 16,
      W_SRC_PORT    = 17,
      W_DST_PORT    = 18,
      W_UDP_LEN     = 19,
      W_UDP_CK      = 20
   } hdr_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEN,
      ST_SUM,
      ST_FOLD,
      ST_EMIT
   } back_state_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [15:0]      header_word;
      logic [IDX_W-1:0] word_index;
      logic             last_word;
      logic             too_long;
   } rsp_type;

   // one finished datagram handed to the back end
   typedef struct packed {
      logic [15:0] sum;
      logic [16:0] count;
   } job_type;

   typedef struct packed {
      logic [47:0] dst_mac;
      logic [47:0] src_mac;
      logic [31:0] src_ip_addr;
      logic [31:0] dst_ip_addr;
      logic [15:0] src_udp_port;
      logic [15:0] dst_udp_port;
   } cfg_type;

   // end-around carry fold of a wide sum down to 16 bits
   function automatic logic [15:0] fold_sum(input logic [SUM_W-1:0] s);
      logic [16:0] f1;
      logic [16:0] f2;
      f1 = {1'b0, s[15:0]} + 17'(s[SUM_W-1:16]);
      f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
      return f2[15:0];
   endfunction

   // header word for a position
   function automatic logic [15:0] header_word_f(
      input logic [IDX_W-1:0] idx,
      input cfg_type          cfg,
      input logic [15:0]      tot_len,
      input logic [15:0]      udp_len,
      input logic [15:0]      ip_ck,
      input logic [15:0]      udp_ck
   );
      logic [15:0] w;
      case (hdr_word_type'(idx))
         W_DST_MAC_HI:  w = cfg.dst_mac[47:32];
         W_DST_MAC_MID: w = cfg.dst_mac[31:16];
         W_DST_MAC_LO:  w = cfg.dst_mac[15:0];
         W_SRC_MAC_HI:  w = cfg.src_mac[47:32];
         W_SRC_MAC_MID: w = cfg.src_mac[31:16];
         W_SRC_MAC_LO:  w = cfg.src_mac[15:0];
         W_ETHERTYPE:   w = ETHERTYPE_IPV4;
         W_VER_IHL:     w = IP_VER_IHL;
         W_TOT_LEN:     w = tot_len;
         W_IDENT:       w = IP_IDENT;
         W_FLAGS:       w = IP_FLAGS_DF;
         W_TTL_PROTO:   w = IP_TTL_PROTO;
         W_IP_CK:       w = ip_ck;
         W_SRC_IP_HI:   w = cfg.src_ip_addr[31:16];
         W_SRC_IP_LO:   w = cfg.src_ip_addr[15:0];
         W_DST_IP_HI:   w = cfg.dst_ip_addr[31:16];
         W_DST_IP_LO:   w = cfg.dst_ip_addr[15:0];
         W_SRC_PORT:    w = cfg.src_udp_port;
         W_DST_PORT:    w = cfg.dst_udp_port;
         W_UDP_LEN:     w = udp_len;
         W_UDP_CK:      w = udp_ck;
         default:       w = 16'd0;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

>>> sv/udp_ipv4_header_builder_top.sv
// channel | direction | beat                          | handshake
// req     | in        | one payload byte + last flag  | req_valid / req_stall
// rsp     | out       | one 16-bit header word        | rsp_valid / rsp_stall
// csr     | in        | 64-bit register write or read | apb, pready tied high
//
// payload bytes are taken one per cycle; req_stall rises only while the two-deep job queue is full
// each datagram takes the header sequencer through pop, lengths, sums, fold and 21 words
// datagrams that arrive faster than the sequencer finishes them back up the queue and stall the byte stream
// a stalled response holds its word in the output register while bytes keep flowing in front
// synchronous active-high reset clears sums, counts, queue, sequencer and registers
`default_nettype none

module udp_ipv4_header_builder_top import udphb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;
   logic    push;
   job_type push_job;
   logic    queue_full;
   logic    queue_empty;
   logic    pop;
   job_type queue_head;

   udphb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   udphb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   udphb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .head     (queue_head)
   );

   udphb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .queue_empty (queue_empty),
      .queue_head  (queue_head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

>>> sv/udphb_csr.sv
`default_nettype none

module udphb_csr import udphb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type reg_idx;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = reg_idx_type'(csr_paddr[CSR_ADDR_W-1:3]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   // register write decode, upper bits dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_DST_MAC:  cfg_in.dst_mac      = csr_pwdata[47:0];
            REG_SRC_MAC:  cfg_in.src_mac      = csr_pwdata[47:0];
            REG_SRC_IP:   cfg_in.src_ip_addr  = csr_pwdata[31:0];
            REG_DST_IP:   cfg_in.dst_ip_addr  = csr_pwdata[31:0];
            REG_SRC_PORT: cfg_in.src_udp_port = csr_pwdata[15:0];
            REG_DST_PORT: cfg_in.dst_udp_port = csr_pwdata[15:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      case (reg_idx)
         REG_DST_MAC:  csr_prdata = CSR_DATA_W'(cfg_ff.dst_mac);
         REG_SRC_MAC:  csr_prdata = CSR_DATA_W'(cfg_ff.src_mac);
         REG_SRC_IP:   csr_prdata = CSR_DATA_W'(cfg_ff.src_ip_addr);
         REG_DST_IP:   csr_prdata = CSR_DATA_W'(cfg_ff.dst_ip_addr);
         REG_SRC_PORT: csr_prdata = CSR_DATA_W'(cfg_ff.src_udp_port);
         REG_DST_PORT: csr_prdata = CSR_DATA_W'(cfg_ff.dst_udp_port);
         default:      csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

>>> sv/udphb_front.sv
`default_nettype none

module udphb_front import udphb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic    queue_full,
   output logic    push,
   output job_type push_job
);

   logic [15:0] sum_ff;
   logic [15:0] sum_in;
   logic [16:0] count_ff;
   logic [16:0] count_in;
   logic [7:0]  pend_ff;
   logic        odd_ff;
   logic        accept;
   logic        add_word;
   logic [15:0] word;
   logic [16:0] raw_sum;
   logic [15:0] folded;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // pair bytes into big-endian words, odd tail padded with zero
   assign word     = odd_ff ? {pend_ff, req_data.payload_byte}
                            : {req_data.payload_byte, 8'h00};
   assign add_word = odd_ff || req_data.last_byte;
   assign raw_sum  = {1'b0, sum_ff} + {1'b0, word};
   assign folded   = raw_sum[15:0] + {15'd0, raw_sum[16]};
   assign sum_in   = add_word ? folded : sum_ff;
   assign count_in = (count_ff < COUNT_CAP) ? count_ff + 17'd1 : count_ff;

   // hand the finished datagram to the queue
   assign push     = accept && req_data.last_byte;
   assign push_job = '{sum: sum_in, count: count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         pend_ff  <= '0;
         odd_ff   <= 1'b0;
      end else if (accept) begin
         if (req_data.last_byte) begin
            sum_ff   <= '0;
            count_ff <= '0;
            pend_ff  <= '0;
            odd_ff   <= 1'b0;
         end else begin
            sum_ff   <= sum_in;
            count_ff <= count_in;
            pend_ff  <= odd_ff ? 8'h00 : req_data.payload_byte;
            odd_ff   <= !odd_ff;
         end
      end
   end

endmodule

`default_nettype wire

>>> sv/udphb_queue.sv
`default_nettype none

module udphb_queue import udphb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type head
);

   job_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   // pointers wrap at the depth
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

>>> sv/udphb_back.sv
`default_nettype none

`include "udp_ipv4_header_builder_top_macros.svh"

module udphb_back import udphb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    queue_empty,
   input  job_type queue_head,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   back_state_type   state_ff;
   back_state_type   state_in;
   job_type          job_ff;
   logic             too_ff;
   logic [15:0]      tot_len_ff;
   logic [15:0]      udp_len_ff;
   logic [17:0]      addr_sum_ff;
   logic [SUM_W-1:0] ip_sum_ff;
   logic [SUM_W-1:0] udp_sum_ff;
   logic [15:0]      ip_ck_ff;
   logic [15:0]      udp_ck_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_data_ff;
   rsp_type          rsp_data_in;
   logic             load_out;
   logic             too_len;
   logic [15:0]      pay_len;
   logic [15:0]      ip_fold;
   logic [15:0]      udp_fold;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // output register takes a word in emit when empty or draining
   assign load_out = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequencer: take a job, build lengths and checksums, stream the words
   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               state_in = ST_LEN;
            end
         end
         ST_LEN:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_FOLD;
         ST_FOLD: state_in = ST_EMIT;
         ST_EMIT: begin
            if (load_out && idx_ff == LAST_WORD_IDX) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // length saturation
   assign too_len = (job_ff.count > MAX_PAYLOAD);
   assign pay_len = too_len ? 16'(MAX_PAYLOAD) : job_ff.count[15:0];

   // final folds
   assign ip_fold  = ~fold_sum(ip_sum_ff);
   assign udp_fold = ~fold_sum(udp_sum_ff);

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= queue_head;
      end
      if (state_ff == ST_LEN) begin
         too_ff      <= too_len;
         tot_len_ff  <= pay_len + IP_HDR_LEN + UDP_HDR_LEN;
         udp_len_ff  <= pay_len + UDP_HDR_LEN;
         addr_sum_ff <= 18'(cfg.src_ip_addr[31:16]) + 18'(cfg.src_ip_addr[15:0])
                      + 18'(cfg.dst_ip_addr[31:16]) + 18'(cfg.dst_ip_addr[15:0]);
      end
      if (state_ff == ST_SUM) begin
         ip_sum_ff  <= SUM_W'(IP_VER_IHL) + SUM_W'(tot_len_ff) + SUM_W'(IP_IDENT)
                     + SUM_W'(IP_FLAGS_DF) + SUM_W'(IP_TTL_PROTO) + SUM_W'(addr_sum_ff);
         udp_sum_ff <= SUM_W'(job_ff.sum) + SUM_W'(addr_sum_ff) + SUM_W'(IP_PROTO_UDP)
                     + SUM_W'(udp_len_ff) + SUM_W'(udp_len_ff)
                     + SUM_W'(cfg.src_udp_port) + SUM_W'(cfg.dst_udp_port);
      end
      if (state_ff == ST_FOLD) begin
         ip_ck_ff  <= ip_fold;
         udp_ck_ff <= (udp_fold == 16'd0) ? UDP_CK_ZERO : udp_fold;
      end
      if (load_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // word counter
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (state_ff == ST_FOLD) begin
         idx_ff <= '0;
      end else if (load_out) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // output beat
   always_comb begin
      rsp_data_in.header_word = header_word_f(idx_ff, cfg, tot_len_ff, udp_len_ff,
                                              ip_ck_ff, udp_ck_ff);
      rsp_data_in.word_index  = idx_ff;
      rsp_data_in.last_word   = (idx_ff == LAST_WORD_IDX);
      rsp_data_in.too_long    = too_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // checks
   `UDPHB_ASSERT_SAME(a_last_word_index, rsp_valid_ff && rsp_data_ff.last_word, rsp_data_ff.word_index == LAST_WORD_IDX, "last word flag away from final index")
   `UDPHB_ASSERT_NEXT(a_emit_done, load_out && idx_ff == LAST_WORD_IDX, state_ff == ST_IDLE, "sequencer did not return to idle after final word")
   `UDPHB_ASSERT_SAME(a_valid_from_emit, $rose(rsp_valid_ff), $past(state_ff) == ST_EMIT, "response beat raised outside emit")
   `UDPHB_ASSERT_SAME(a_sat_udp_len, rsp_valid_ff && rsp_data_ff.too_long && rsp_data_ff.word_index == W_UDP_LEN, rsp_data_ff.header_word == UDP_LEN_SAT, "udp length not saturated on long payload")

endmodule

`default_nettype wire

>>> test/udphb_checker.sv
`default_nettype none

module udphb_checker import udphb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,
   output int                    fail_count,
   output int                    words_due
);
   timeunit 1ns;
   timeprecision 1ps;

   // payload limits and fixed header values
   localparam logic [16:0] LONGEST_PAYLOAD = 17'd65507;
   localparam logic [16:0] BYTE_COUNT_CAP  = 17'd65508;
   localparam logic [15:0] PROTO_UDP       = 16'h0011;

   // register mirror
   logic [47:0] dst_mac_r;
   logic [47:0] src_mac_r;
   logic [31:0] src_ip_r;
   logic [31:0] dst_ip_r;
   logic [15:0] src_port_r;
   logic [15:0] dst_port_r;

   // running payload state
   logic [15:0] payload_sum;
   logic [16:0] payload_count;
   logic [7:0]  held_byte;
   logic        byte_held;

   rsp_type header_due[$];
   int      fails = 0;

   // end-around carry addition of one 16-bit term
   function automatic logic [15:0] csum_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   // expected 21 header words for the datagram just closed
   function automatic void build_header();
      logic [15:0] w [HDR_WORDS];
      logic [15:0] n;
      logic [15:0] ulen;
      logic [15:0] s;
      logic [15:0] udp_ck;
      logic        too;
      rsp_type     item;
      too  = payload_count > LONGEST_PAYLOAD;
      n    = too ? LONGEST_PAYLOAD[15:0] : payload_count[15:0];
      ulen = n + 16'd8;
      w[W_DST_MAC_HI]  = dst_mac_r[47:32];
      w[W_DST_MAC_MID] = dst_mac_r[31:16];
      w[W_DST_MAC_LO]  = dst_mac_r[15:0];
      w[W_SRC_MAC_HI]  = src_mac_r[47:32];
      w[W_SRC_MAC_MID] = src_mac_r[31:16];
      w[W_SRC_MAC_LO]  = src_mac_r[15:0];
      w[W_ETHERTYPE]   = 16'h0800;
      w[W_VER_IHL]     = 16'h4500;
      w[W_TOT_LEN]     = n + 16'd28;
      w[W_IDENT]       = 16'h0000;
      w[W_FLAGS]       = 16'h4000;
      w[W_TTL_PROTO]   = {8'd64, PROTO_UDP[7:0]};
      w[W_SRC_IP_HI]   = src_ip_r[31:16];
      w[W_SRC_IP_LO]   = src_ip_r[15:0];
      w[W_DST_IP_HI]   = dst_ip_r[31:16];
      w[W_DST_IP_LO]   = dst_ip_r[15:0];
      w[W_SRC_PORT]    = src_port_r;
      w[W_DST_PORT]    = dst_port_r;
      w[W_UDP_LEN]     = ulen;

      // ip header checksum over everything but itself
      s = 16'd0;
      for (int i = W_VER_IHL; i <= W_TTL_PROTO; i++) s = csum_add(s, w[i]);
      for (int i = W_SRC_IP_HI; i <= W_DST_IP_LO; i++) s = csum_add(s, w[i]);
      w[W_IP_CK] = ~s;

      // udp checksum: payload, pseudo header, udp header
      s = payload_sum;
      for (int i = W_SRC_IP_HI; i <= W_DST_IP_LO; i++) s = csum_add(s, w[i]);
      s = csum_add(s, PROTO_UDP);
      s = csum_add(s, ulen);
      s = csum_add(s, src_port_r);
      s = csum_add(s, dst_port_r);
      s = csum_add(s, ulen);
      udp_ck = ~s;
      // a zero checksum goes out as all ones
      if (udp_ck == 16'd0) udp_ck = 16'hffff;
      w[W_UDP_CK] = udp_ck;

      for (int i = 0; i < HDR_WORDS; i++) begin
         item.header_word = w[i];
         item.word_index  = IDX_W'(i);
         item.last_word   = (i == HDR_WORDS - 1);
         item.too_long    = too;
         header_due.push_back(item);
      end
   endfunction

   // fold one payload beat into the running state
   function automatic void absorb_byte(input logic [7:0] b, input logic last);
      if (payload_count < BYTE_COUNT_CAP) payload_count = payload_count + 17'd1;
      if (byte_held) begin
         payload_sum = csum_add(payload_sum, {held_byte, b});
         byte_held   = 1'b0;
         held_byte   = 8'd0;
      end else if (last) begin
         // odd length: pad the final byte with a zero low byte
         payload_sum = csum_add(payload_sum, {b, 8'd0});
      end else begin
         held_byte = b;
         byte_held = 1'b1;
      end
      if (last) begin
         build_header();
         payload_sum   = 16'd0;
         payload_count = 17'd0;
         held_byte     = 8'd0;
         byte_held     = 1'b0;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type     want;
      logic [63:0] mirror;
      logic        known;
      if (reset) begin
         dst_mac_r     = '0;
         src_mac_r     = '0;
         src_ip_r      = '0;
         dst_ip_r      = '0;
         src_port_r    = '0;
         dst_port_r    = '0;
         payload_sum   = '0;
         payload_count = '0;
         held_byte     = '0;
         byte_held     = 1'b0;
         header_due.delete();
      end else begin
         // result beat against the oldest expected word
         if (rsp_valid && !rsp_stall) begin
            if (header_due.size() == 0) begin
               $error("unexpected header word %h at index %0d",
                      rsp_data.header_word, rsp_data.word_index);
               fails++;
            end else begin
               want = header_due.pop_front();
               if (rsp_data.header_word !== want.header_word) begin
                  $error("header_word (index %0d): expected %h, actual %h",
                         want.word_index, want.header_word, rsp_data.header_word);
                  fails++;
               end
               if (rsp_data.word_index !== want.word_index) begin
                  $error("word_index: expected %0d, actual %0d",
                         want.word_index, rsp_data.word_index);
                  fails++;
               end
               if (rsp_data.last_word !== want.last_word) begin
                  $error("last_word (index %0d): expected %b, actual %b",
                         want.word_index, want.last_word, rsp_data.last_word);
                  fails++;
               end
               if (rsp_data.too_long !== want.too_long) begin
                  $error("too_long (index %0d): expected %b, actual %b",
                         want.word_index, want.too_long, rsp_data.too_long);
                  fails++;
               end
            end
         end

         // register access phase
         if (csr_psel && csr_penable && csr_pready) begin
            known = 1'b1;
            mirror = '0;
            case (reg_idx_type'(csr_paddr[CSR_ADDR_W-1:3]))
               REG_DST_MAC: begin
                  if (csr_pwrite) dst_mac_r = csr_pwdata[47:0];
                  mirror = {16'd0, dst_mac_r};
               end
               REG_SRC_MAC: begin
                  if (csr_pwrite) src_mac_r = csr_pwdata[47:0];
                  mirror = {16'd0, src_mac_r};
               end
               REG_SRC_IP: begin
                  if (csr_pwrite) src_ip_r = csr_pwdata[31:0];
                  mirror = {32'd0, src_ip_r};
               end
               REG_DST_IP: begin
                  if (csr_pwrite) dst_ip_r = csr_pwdata[31:0];
                  mirror = {32'd0, dst_ip_r};
               end
               REG_SRC_PORT: begin
                  if (csr_pwrite) src_port_r = csr_pwdata[15:0];
                  mirror = {48'd0, src_port_r};
               end
               REG_DST_PORT: begin
                  if (csr_pwrite) dst_port_r = csr_pwdata[15:0];
                  mirror = {48'd0, dst_port_r};
               end
               default: known = 1'b0;
            endcase
            if (!csr_pwrite && known && csr_prdata !== mirror) begin
               $error("csr_prdata (addr %h): expected %h, actual %h",
                      csr_paddr, mirror, csr_prdata);
               fails++;
            end
         end

         // payload beat
         if (req_valid && !req_stall)
            absorb_byte(req_data.payload_byte, req_data.last_byte);
      end
      fail_count <= fails;
      words_due  <= header_due.size();
   end

endmodule

`default_nettype wire

>>> test/tb_top.sv
`default_nettype none

module tb_top import udphb_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_BEAT
   } stall_mode_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int fail_count;
   int words_due;

   // sender burst shaping
   int burst_left = 0;
   int burst_max  = 12;
   int gap_max    = 6;
   int bytes_sent = 0;

   // receiver stall pattern
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;
   logic [7:0]     beat_cnt   = '0;

   udp_ipv4_header_builder_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   udphb_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .words_due   (words_due)
   );

   always #5 clock = ~clock;

   // receiver stalls, switching between patterns every so often
   always @(posedge clock) begin
      beat_cnt <= beat_cnt + 8'd1;
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(STALL_NONE, STALL_BEAT));
         stall_left <= $urandom_range(20, 300);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 9) < 3);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 8);
         default:     rsp_stall <= beat_cnt[2];
      endcase
   end

   // apb write: setup then access, then psel and penable dropped
   task automatic csr_write(input int idx, input logic [63:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx * 8);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(input int idx);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(idx * 8);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // write all six registers, then read them back
   task automatic load_config(input logic [63:0] dm, input logic [63:0] sm,
                              input logic [63:0] sip, input logic [63:0] dip,
                              input logic [63:0] sp, input logic [63:0] dp);
      csr_write(REG_DST_MAC, dm);
      csr_write(REG_SRC_MAC, sm);
      csr_write(REG_SRC_IP, sip);
      csr_write(REG_DST_IP, dip);
      csr_write(REG_SRC_PORT, sp);
      csr_write(REG_DST_PORT, dp);
      for (int i = REG_DST_MAC; i <= REG_DST_PORT; i++) csr_read(i);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // one payload beat, with bursts and gaps around it
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, burst_max);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= '{payload_byte: b, last_byte: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_datagram(input int len);
      for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), i == len - 1);
   endtask

   // drain all headers before touching registers
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   initial begin
      int len;
      int phase;
      int pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers straight out of reset
      for (int i = REG_DST_MAC; i <= REG_DST_PORT; i++) csr_read(i);

      // zero udp checksum: with reset registers the pseudo header and udp header sum to 0025
      send_byte(8'hff, 1'b0);
      send_byte(8'hda, 1'b1);
      settle();

      // writes past the last register are ignored
      csr_write(REG_COUNT, rand64());
      csr_write(REG_COUNT + 1, rand64());

      // all ones, upper bits masked off
      load_config({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b1);
      send_byte(8'hab, 1'b0);
      send_byte(8'hcd, 1'b0);
      send_byte(8'hef, 1'b1);
      for (int i = 0; i < 4; i++) send_byte(8'hff, i == 3);
      send_byte(8'h5a, 1'b0);
      send_byte(8'ha5, 1'b1);
      settle();

      // alternating bit patterns
      load_config({32{2'b10}}, {32{2'b01}}, {32{2'b10}}, {32{2'b01}},
                  {32{2'b10}}, {32{2'b01}});
      send_datagram(8);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      settle();

      // random datagrams, registers changed between phases
      phase = 0;
      while (bytes_sent < 220) begin
         if (phase == 2)
            load_config('0, '0, '0, '0, '0, '0);
         else
            load_config(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
         repeat ($urandom_range(4, 8)) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)      len = $urandom_range(1, 8);
            else if (pick < 9) len = $urandom_range(9, 40);
            else               len = $urandom_range(41, 100);
            send_datagram(len);
         end
         settle();
         phase++;
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule

`default_nettype wire
